/* hw/rtl/lru_fully_associative_cache_macros.svh */
// Assertion macros shared by the cache RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef LRU_FULLY_ASSOCIATIVE_CACHE_MACROS_SVH
`define LRU_FULLY_ASSOCIATIVE_CACHE_MACROS_SVH

`ifndef SYNTH
// check prop on every edge outside reset
`define LFAC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lfac check failed");
// check prop on every edge, reset included
`define LFAC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("lfac check failed");
`else
`define LFAC_ASSERT(label, clk, rst, prop)
`define LFAC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

/* hw/rtl/lfac_pkg.sv */
// Shared types and constants of the LRU cache: opcodes and the command
// passed from the front end to the execution side. No dependencies.
package lfac_pkg;

   localparam int KEY_W      = 32;
   localparam int WDATA_W    = 32;
   localparam int RDATA_W    = 32;
   localparam int OPCODE_W   = 2;
   localparam int TARGET_W   = 3;
   localparam int RSP_SLOT_W = 3;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOOKUP     = 2'd0,
      OP_INSERT     = 2'd1,
      OP_INVALIDATE = 2'd2,
      OP_FLUSH      = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type          op;
      logic [KEY_W-1:0]    key;
      logic [WDATA_W-1:0]  write_data;
      logic [TARGET_W-1:0] target_slot;
      logic                target_ok;
   } cmd_type;

endpackage

/* hw/rtl/lfac_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lfac_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/lfac_front.sv */
// Front end of the LRU cache: decodes each request beat and queues it.
// Depends on lfac_pkg.
module lfac_front #(
   parameter int ENTRIES = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [lfac_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [lfac_pkg::KEY_W-1:0]      req_key,
   input  logic [lfac_pkg::WDATA_W-1:0]    req_write_data,
   input  logic [lfac_pkg::TARGET_W-1:0]   req_target_slot,
   output logic                            cmd_valid,
   input  logic                            cmd_ready,
   output lfac_pkg::cmd_type               cmd
);
   import lfac_pkg::*;

   localparam int QDEPTH = 2;
   localparam int PTR_W  = $clog2(QDEPTH);
   localparam int CNT_W  = $clog2(QDEPTH + 1);
   localparam int CMP_W  = $clog2(ENTRIES) + TARGET_W + 1;

   cmd_type          queue_ff [QDEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   cmd_type    decoded;
   logic       push;
   logic       pop;
   logic [CMP_W-1:0] target_ext;

   // classify
   always_comb begin
      target_ext = CMP_W'(req_target_slot);
      decoded.key         = req_key;
      decoded.write_data  = req_write_data;
      decoded.target_slot = req_target_slot;
      decoded.target_ok   = 1'b0;
      unique case (req_opcode)
         OP_LOOKUP: decoded.op = OP_LOOKUP;
         OP_INSERT: decoded.op = OP_INSERT;
         OP_INVALIDATE: begin
            decoded.op        = OP_INVALIDATE;
            decoded.target_ok = target_ext < CMP_W'(ENTRIES);
         end
         default: decoded.op = OP_FLUSH;
      endcase
   end

   assign req_ready = count_ff != CNT_W'(QDEPTH);
   assign push      = req_valid && req_ready;
   assign cmd_valid = count_ff != '0;
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

/* hw/rtl/lfac_back.sv */
// Execution side of the LRU cache: key match, recency update, entry
// storage and response register. Depends on lfac_pkg, lfac_ram and the
// assertion macro header.
`include "lru_fully_associative_cache_macros.svh"
module lfac_back #(
   parameter int ENTRIES    = 8,
   parameter int DATA_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   output logic                             cmd_ready,
   input  lfac_pkg::cmd_type                cmd,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_hit,
   output logic [lfac_pkg::RSP_SLOT_W-1:0]  rsp_slot,
   output logic [lfac_pkg::RDATA_W-1:0]     rsp_read_data
);
   import lfac_pkg::*;

   localparam int SLOT_W = $clog2(ENTRIES);
   localparam int EXT_W  = SLOT_W + TARGET_W;

   typedef enum logic {ST_MATCH, ST_EXEC} state_type;

   state_type state_ff, state_in;

   logic [KEY_W-1:0]  key_ff [ENTRIES];
   logic [KEY_W-1:0]  key_in [ENTRIES];
   logic [SLOT_W-1:0] rank_ff [ENTRIES];
   logic [SLOT_W-1:0] rank_in [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;

   cmd_type            cmd_ff;
   logic [ENTRIES-1:0] match_ff, match_in;
   logic [ENTRIES-1:0] lru_ff, lru_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [RSP_SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                  rsp_rdsel_ff, rsp_rdsel_in;

   logic                  take;
   logic                  exec;
   logic                  hit;
   logic [ENTRIES-1:0]    tgt_hot;
   logic [ENTRIES-1:0]    sel;
   logic [SLOT_W-1:0]     sel_idx;
   logic [SLOT_W-1:0]     sel_rank;
   logic [EXT_W-1:0]      target_ext;
   logic [SLOT_W+RSP_SLOT_W-1:0] slot_ext;

   logic                    ram_wr_en;
   logic                    ram_rd_en;
   logic [DATA_WIDTH-1:0]   ram_wr_data;
   logic [DATA_WIDTH-1:0]   ram_rd_data;
   logic [DATA_WIDTH+WDATA_W-1:0]   wr_wide;
   logic [DATA_WIDTH+RDATA_W-1:0]   rd_wide;

   assign cmd_ready = state_ff == ST_MATCH;
   assign take      = cmd_valid && cmd_ready;
   assign exec      = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign hit       = |match_ff;

   // match against current entries
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_in[i] = valid_ff[i] && (key_ff[i] == cmd.key);
         lru_in[i]   = rank_ff[i] == SLOT_W'(ENTRIES - 1);
      end
   end

   // select the slot that the command acts on
   always_comb begin
      target_ext = EXT_W'(cmd_ff.target_slot);
      for (int i = 0; i < ENTRIES; i++) begin
         tgt_hot[i] = target_ext == EXT_W'(i);
      end
      unique case (cmd_ff.op)
         OP_LOOKUP:     sel = match_ff;
         OP_INSERT:     sel = hit ? match_ff : lru_ff;
         OP_INVALIDATE: sel = cmd_ff.target_ok ? tgt_hot : '0;
         OP_FLUSH:      sel = '0;
      endcase
      sel_idx  = '0;
      sel_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         sel_idx  = sel_idx | (sel[i] ? SLOT_W'(i) : '0);
         sel_rank = sel_rank | (sel[i] ? rank_ff[i] : '0);
      end
   end

   // entry state update
   always_comb begin
      valid_in = valid_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         key_in[i]  = key_ff[i];
         rank_in[i] = rank_ff[i];
      end
      if (exec) begin
         case (cmd_ff.op)
            OP_LOOKUP, OP_INSERT: begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (sel[i]) begin
                     rank_in[i] = '0;
                  end else if (rank_ff[i] < sel_rank) begin
                     rank_in[i] = rank_ff[i] + SLOT_W'(1);
                  end
                  if (sel[i] && cmd_ff.op == OP_INSERT) begin
                     key_in[i]   = cmd_ff.key;
                     valid_in[i] = 1'b1;
                  end
               end
            end
            OP_INVALIDATE: begin
               if (|sel) begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (sel[i]) begin
                        rank_in[i]  = SLOT_W'(ENTRIES - 1);
                        valid_in[i] = 1'b0;
                     end else if (rank_ff[i] > sel_rank) begin
                        rank_in[i] = rank_ff[i] - SLOT_W'(1);
                     end
                  end
               end
            end
            default: valid_in = '0;
         endcase
      end
   end

   // sequencing and response register
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_rdsel_in = rsp_rdsel_ff;
      slot_ext     = (SLOT_W + RSP_SLOT_W)'(sel_idx);
      unique case (state_ff)
         ST_MATCH: begin
            if (take) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec) begin
               state_in     = ST_MATCH;
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit && (cmd_ff.op == OP_LOOKUP || cmd_ff.op == OP_INSERT);
               rsp_rdsel_in = hit && cmd_ff.op == OP_LOOKUP;
               rsp_slot_in  = (rsp_rdsel_in || cmd_ff.op == OP_INSERT) ?
                              slot_ext[RSP_SLOT_W-1:0] : '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_MATCH;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_hit_ff   <= rsp_hit_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_rdsel_ff <= rsp_rdsel_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= SLOT_W'(i);
         end
      end else begin
         valid_ff <= valid_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
      for (int i = 0; i < ENTRIES; i++) begin
         key_ff[i] <= key_in[i];
      end
      if (take) begin
         cmd_ff   <= cmd;
         match_ff <= match_in;
         lru_ff   <= lru_in;
      end
   end

   // data store
   assign wr_wide     = {{DATA_WIDTH{1'b0}}, cmd_ff.write_data};
   assign ram_wr_data = wr_wide[DATA_WIDTH-1:0];
   assign ram_wr_en   = exec && cmd_ff.op == OP_INSERT;
   assign ram_rd_en   = exec && cmd_ff.op == OP_LOOKUP && hit;

   lfac_ram #(
      .WIDTH(DATA_WIDTH),
      .DEPTH(ENTRIES)
   ) u_data_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(sel_idx),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(sel_idx),
      .rd_data(ram_rd_data)
   );

   assign rd_wide       = {{RDATA_W{1'b0}}, ram_rd_data};
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_read_data = rsp_rdsel_ff ? rd_wide[RDATA_W-1:0] : '0;

   `LFAC_ASSERT(a_match_unique, clock, reset, state_ff == ST_EXEC |-> $onehot0(match_ff))
   `LFAC_ASSERT(a_lru_single, clock, reset, state_ff == ST_EXEC |-> $onehot(lru_ff))
   `LFAC_ASSERT(a_rsp_from_exec, clock, reset, $rose(rsp_valid_ff) |-> $past(exec))
   `LFAC_ASSERT(a_data_needs_hit, clock, reset, rsp_valid_ff && rsp_rdsel_ff |-> rsp_hit_ff)

endmodule

/* hw/rtl/lru_fully_associative_cache.sv */
// Fully associative key-to-data cache with a full LRU order. A request beat
// goes into a two-deep queue in the front end; the execution side then first
// matches the key against every valid entry and registers the result, then
// updates recency, valid bits, keys and the data RAM and loads the response
// register; the update waits while an earlier response is still unaccepted.
// It takes no new request from the queue until the previous one has loaded
// its response. Reset needs no clearing pass: valid bits and ranks reset at
// once, and slot 0 starts most recent.
// Depends on lfac_pkg, lfac_front, lfac_back and lfac_ram.
module lru_fully_associative_cache #(
   parameter int ENTRIES    = 8,
   parameter int DATA_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [lfac_pkg::OPCODE_W-1:0]    req_opcode,
   input  logic [lfac_pkg::KEY_W-1:0]       req_key,
   input  logic [lfac_pkg::WDATA_W-1:0]     req_write_data,
   input  logic [lfac_pkg::TARGET_W-1:0]    req_target_slot,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_hit,
   output logic [lfac_pkg::RSP_SLOT_W-1:0]  rsp_slot,
   output logic [lfac_pkg::RDATA_W-1:0]     rsp_read_data
);
   import lfac_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_ready;

   lfac_front #(
      .ENTRIES(ENTRIES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_key        (req_key),
      .req_write_data (req_write_data),
      .req_target_slot(req_target_slot),
      .cmd_valid      (cmd_valid),
      .cmd_ready      (cmd_ready),
      .cmd            (cmd)
   );

   lfac_back #(
      .ENTRIES   (ENTRIES),
      .DATA_WIDTH(DATA_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd_ready    (cmd_ready),
      .cmd          (cmd),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_hit      (rsp_hit),
      .rsp_slot     (rsp_slot),
      .rsp_read_data(rsp_read_data)
   );

endmodule

/* dv/tb_lru_fully_associative_cache.sv */
// Self-checking testbench for lru_fully_associative_cache: directed and random
// request beats, checked against a shadow LRU cache kept in the testbench.
// Depends on lfac_pkg and the lru_fully_associative_cache RTL.
`timescale 1ns / 100ps

module tb_lru_fully_associative_cache;
   import lfac_pkg::*;

   localparam int NUM_SLOTS   = 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 90;
   localparam int DRAIN_CYCLES = 12;

   typedef struct {
      opcode_type          op;
      logic [KEY_W-1:0]    key;
      logic [WDATA_W-1:0]  wdata;
      logic [TARGET_W-1:0] target;
   } cache_req_t;

   typedef struct {
      logic                  hit;
      logic [RSP_SLOT_W-1:0] slot;
      logic [RDATA_W-1:0]    rdata;
   } cache_rsp_t;

   logic                  clock;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_ready;
   logic [OPCODE_W-1:0]   req_opcode      = '0;
   logic [KEY_W-1:0]      req_key         = '0;
   logic [WDATA_W-1:0]    req_write_data  = '0;
   logic [TARGET_W-1:0]   req_target_slot = '0;
   logic                  rsp_valid;
   logic                  rsp_ready       = 1'b0;
   logic                  rsp_hit;
   logic [RSP_SLOT_W-1:0] rsp_slot;
   logic [RDATA_W-1:0]    rsp_read_data;

   cache_req_t req_backlog[$];
   cache_rsp_t expected_cache_rsp[$];
   cache_req_t cur_req;

   logic [KEY_W-1:0]   shadow_key  [NUM_SLOTS];
   logic [RDATA_W-1:0] shadow_data [NUM_SLOTS];
   bit                 shadow_vld  [NUM_SLOTS];
   int unsigned        shadow_rank [NUM_SLOTS];

   logic [KEY_W-1:0] key_pool [12];

   int unsigned total_items;
   int unsigned beats_sent;
   int unsigned rsp_checked;
   int unsigned fail_count;
   int unsigned cycle_count;
   int unsigned hold_left;
   int unsigned holds_done;
   int unsigned lookup_hits;
   int unsigned insert_hits;
   int unsigned replacements;
   int unsigned invalidates;
   int unsigned flushes;

   lru_fully_associative_cache #(
      .ENTRIES    (NUM_SLOTS),
      .DATA_WIDTH (RDATA_W)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_key         (req_key),
      .req_write_data  (req_write_data),
      .req_target_slot (req_target_slot),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_slot        (rsp_slot),
      .rsp_read_data   (rsp_read_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // move slot to most recent, aging every slot that was more recent
   function automatic void promote_slot(int s);
      int unsigned r;
      r = shadow_rank[s];
      for (int i = 0; i < NUM_SLOTS; i++)
         if (shadow_rank[i] < r) shadow_rank[i]++;
      shadow_rank[s] = 0;
   endfunction

   function automatic cache_rsp_t shadow_cache_access(cache_req_t rq);
      cache_rsp_t rs;
      int         s;
      int unsigned r;
      rs.hit   = 1'b0;
      rs.slot  = '0;
      rs.rdata = '0;
      s = -1;
      for (int i = 0; i < NUM_SLOTS; i++)
         if (shadow_vld[i] && shadow_key[i] == rq.key &&
             (s < 0 || shadow_rank[i] < shadow_rank[s])) s = i;
      case (rq.op)
         OP_LOOKUP: begin
            if (s >= 0) begin
               promote_slot(s);
               rs.hit   = 1'b1;
               rs.slot  = 3'(s);
               rs.rdata = shadow_data[s];
               lookup_hits++;
            end
         end
         OP_INSERT: begin
            if (s >= 0) begin
               rs.hit = 1'b1;
               insert_hits++;
            end else begin
               for (int i = 0; i < NUM_SLOTS; i++)
                  if (shadow_rank[i] == NUM_SLOTS - 1) s = i;
               replacements++;
            end
            shadow_key[s]  = rq.key;
            shadow_data[s] = rq.wdata;
            shadow_vld[s]  = 1'b1;
            promote_slot(s);
            rs.slot = 3'(s);
         end
         OP_INVALIDATE: begin
            if (rq.target < NUM_SLOTS) begin
               r = shadow_rank[rq.target];
               shadow_vld[rq.target] = 1'b0;
               for (int i = 0; i < NUM_SLOTS; i++)
                  if (shadow_rank[i] > r) shadow_rank[i]--;
               shadow_rank[rq.target] = NUM_SLOTS - 1;
            end
            invalidates++;
         end
         default: begin
            for (int i = 0; i < NUM_SLOTS; i++) shadow_vld[i] = 1'b0;
            flushes++;
         end
      endcase
      return rs;
   endfunction

   task automatic queue_req(opcode_type op, logic [KEY_W-1:0] key,
                            logic [WDATA_W-1:0] wdata, logic [TARGET_W-1:0] target);
      cache_req_t rq;
      rq.op     = op;
      rq.key    = key;
      rq.wdata  = wdata;
      rq.target = target;
      req_backlog.push_back(rq);
   endtask

   function automatic int unsigned idle_pct(bit sender);
      int unsigned phase;
      phase = (total_items == 0) ? 0 : beats_sent * 3 / total_items;
      if (phase == 0) return sender ? 22 : 45;
      if (phase == 1) return sender ? 45 : 22;
      return 0;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_cache_rsp.push_back(shadow_cache_access(cur_req));
            beats_sent <= beats_sent + 1;
         end
         if (!req_valid || req_ready) begin
            if (req_backlog.size() != 0 &&
                (hold_left != 0 || $urandom_range(99) >= idle_pct(1'b1))) begin
               cur_req = req_backlog.pop_front();
               req_opcode      <= cur_req.op;
               req_key         <= cur_req.key;
               req_write_data  <= cur_req.wdata;
               req_target_slot <= cur_req.target;
               req_valid       <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long response hold-off while requests keep coming
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         holds_done <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if ((holds_done == 0 && beats_sent >= 60) ||
                   (holds_done == 1 && beats_sent >= 430)) begin
         hold_left  <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_cache_rsp.size() == 0) begin
               $error("unexpected response beat: hit %0d slot %0d read_data %h",
                      rsp_hit, rsp_slot, rsp_read_data);
               fail_count++;
            end else begin
               automatic cache_rsp_t exp_rsp = expected_cache_rsp.pop_front();
               if (rsp_hit !== exp_rsp.hit) begin
                  $error("hit mismatch: expected %0d, actual %0d", exp_rsp.hit, rsp_hit);
                  fail_count++;
               end
               if (rsp_slot !== exp_rsp.slot) begin
                  $error("slot mismatch: expected %0d, actual %0d", exp_rsp.slot, rsp_slot);
                  fail_count++;
               end
               if (rsp_read_data !== exp_rsp.rdata) begin
                  $error("read_data mismatch: expected %h, actual %h",
                         exp_rsp.rdata, rsp_read_data);
                  fail_count++;
               end
               rsp_checked++;
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b0));
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("lru_fully_associative_cache test failed");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         shadow_key[i]  = '0;
         shadow_data[i] = '0;
         shadow_vld[i]  = 1'b0;
         shadow_rank[i] = i;
      end
      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = $urandom;
      key_pool[3] = key_pool[2] ^ 32'h1;
      key_pool[4] = key_pool[2] ^ 32'h8000_0000;
      for (int i = 5; i < 12; i++) key_pool[i] = $urandom;

      // directed: empty miss, extreme keys and data, update, fill, evict,
      // invalidate of valid and invalid slots, flush
      queue_req(OP_LOOKUP, '0, '0, '0);
      queue_req(OP_INSERT, '0, '0, '0);
      queue_req(OP_INSERT, '1, '1, '1);
      queue_req(OP_LOOKUP, '1, '0, '0);
      queue_req(OP_LOOKUP, '0, '1, '1);
      queue_req(OP_INSERT, '0, 32'hAAAA_5555, '0);
      queue_req(OP_LOOKUP, '0, '0, '0);
      queue_req(OP_INVALIDATE, '0, '0, 3'd3);
      for (int i = 1; i <= 6; i++)
         queue_req(OP_INSERT, 32'(i), 32'h5555_AAAA + i, '0);
      queue_req(OP_INSERT, 32'h1234_5678, 32'hDEAD_BEEF, '0);
      queue_req(OP_LOOKUP, 32'd1, '0, '0);
      queue_req(OP_INVALIDATE, '0, '0, 3'd7);
      queue_req(OP_INVALIDATE, '0, '0, 3'd0);
      queue_req(OP_INSERT, 32'hFFFF_FFFE, 32'h0000_0001, '0);
      queue_req(OP_LOOKUP, '1, '0, '0);
      queue_req(OP_FLUSH, '1, '1, '1);
      queue_req(OP_LOOKUP, '1, '0, '0);
      queue_req(OP_INSERT, '1, 32'h8000_0000, '0);
      queue_req(OP_LOOKUP, '1, '0, '0);

      for (int n = 0; n < 750; n++) begin
         automatic int unsigned roll = $urandom_range(99);
         automatic opcode_type  op;
         automatic logic [KEY_W-1:0] key;
         if (roll < 40)      op = OP_LOOKUP;
         else if (roll < 75) op = OP_INSERT;
         else if (roll < 94) op = OP_INVALIDATE;
         else                op = OP_FLUSH;
         key = ($urandom_range(3) != 0) ? key_pool[$urandom_range(11)] : $urandom;
         queue_req(op, key, $urandom, 3'($urandom_range(7)));
      end
      total_items = req_backlog.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_valid) @(posedge clock);
      while (expected_cache_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests, %0d responses checked, %0d response hold-offs",
               total_items, rsp_checked, holds_done);
      $display("lookup hits %0d, insert updates %0d, replacements %0d, invalidates %0d, flushes %0d",
               lookup_hits, insert_hits, replacements, invalidates, flushes);
      if (fail_count == 0) begin
         $display("lru_fully_associative_cache test passed");
      end else begin
         $display("lru_fully_associative_cache test failed");
      end
      $finish;
   end

endmodule
